// ===== rtl/tcgb_pkg.sv =====
`timescale 1ns / 1ps

package tcgb_pkg;

  localparam int GLYPH_ROWS  = 16;
  localparam int GLYPH_COUNT = 256;
  localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
  localparam int ROW_W       = $clog2(GLYPH_ROWS);
  localparam int FONT_AW     = GLYPH_IDX_W + ROW_W;
  localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_ROWS;

  localparam int CUR_W  = 14;
  localparam int ADDR_W = 34;
  // pixel offset x + y*stride, with y up to the saturated value plus the last glyph row
  localparam int OFF_W  = 29;
  localparam int DATA_W = 32;
  localparam int PADDR_W = 5;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  localparam logic [CUR_W-1:0] CUR_HOME_X = CUR_W'(8);
  localparam logic [CUR_W-1:0] CUR_HOME_Y = CUR_W'(16);
  localparam logic [CUR_W-1:0] CUR_MAX    = '1;
  localparam logic [CUR_W-1:0] CHAR_STEP  = CUR_W'(8);
  localparam logic [CUR_W-1:0] TAB_STEP   = CUR_W'(32);
  localparam logic [CUR_W-1:0] LINE_STEP  = CUR_W'(16);

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_TAB = 8'h09;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_ROWS - 1);

  typedef enum logic [1:0] {
    OP_PRINT = 2'd0,
    OP_LOAD  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_GLYPH = 2'd2
  } cmd_kind_t;

  typedef enum logic {
    KIND_ROW   = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    REG_FRAME_BASE    = 3'd0,
    REG_LINE_STRIDE   = 3'd1,
    REG_SCREEN_WIDTH  = 3'd2,
    REG_SCREEN_HEIGHT = 3'd3,
    REG_TEXT_COLOR    = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    B_IDLE  = 2'd0,
    B_CLEAR = 2'd1,
    B_MUL   = 2'd2,
    B_ROWS  = 2'd3
  } bstate_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic                   pre_clear;
    logic [CUR_W-1:0]       x;
    logic [CUR_W-1:0]       y;
    logic [GLYPH_IDX_W-1:0] glyph;
    logic [ROW_W-1:0]       row;
    logic [7:0]             bits;
  } cmd_t;

  function automatic logic [CUR_W-1:0] sat_add(input logic [CUR_W-1:0] a,
                                               input logic [CUR_W-1:0] b);
    logic [CUR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CUR_W] ? CUR_MAX : s[CUR_W-1:0];
  endfunction

endpackage

// ===== rtl/text_console_glyph_blitter.sv =====
// A clear word passes the queue entry and the back end's command register before the output
// register; glyph rows also wait for the row-offset multiply and for any clear ahead of them.
// A printed glyph is dequeued, its row offset multiplied, then one row per cycle is read, while
// the output does not stall, from the single read port of the font store. The four-entry command
// queue lets the input side run ahead of the row writer.
// Reset (rst_n, synchronous, active low) homes the cursor to (8,16) and empties the queue.
`timescale 1ns / 1ps

module text_console_glyph_blitter (
  input  logic                              clk,
  input  logic                              rst_n,
  // command channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_opcode,
  input  logic [7:0]                        in_char_code,
  input  logic [3:0]                        in_font_row,
  input  logic [7:0]                        in_font_bits,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_kind,
  output logic [tcgb_pkg::ADDR_W-1:0]       out_byte_address,
  output logic [7:0]                        out_row_mask,
  output logic [31:0]                       out_pixel_color,
  output logic                              out_last,
  // register port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [tcgb_pkg::PADDR_W-1:0]      cfg_paddr,
  input  logic [tcgb_pkg::DATA_W-1:0]       cfg_pwdata,
  output logic [tcgb_pkg::DATA_W-1:0]       cfg_prdata,
  output logic                              cfg_pready
);

  // Reset restores register defaults; the font store is not cleared and must be loaded before use.

  // Configuration registers; users write only while the pipeline is drained; not enforced.
  logic [31:0]                frame_base_r;
  logic [tcgb_pkg::CUR_W-1:0] line_stride_r;
  logic [tcgb_pkg::CUR_W-1:0] screen_width_r;
  logic [tcgb_pkg::CUR_W-1:0] screen_height_r;
  logic [31:0]                text_color_r;
  tcgb_pkg::reg_idx_t         reg_idx;
  logic                       cfg_write;

  // Front/back hand-off.
  logic           q_push, q_full, q_pop, q_valid;
  tcgb_pkg::cmd_t q_wdata, q_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;
  // Word-aligned map: drop the byte offset bits.
  assign reg_idx    = tcgb_pkg::reg_idx_t'(cfg_paddr[tcgb_pkg::PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r    <= '0;
      line_stride_r   <= tcgb_pkg::CUR_W'(1024);
      screen_width_r  <= tcgb_pkg::CUR_W'(1024);
      screen_height_r <= tcgb_pkg::CUR_W'(768);
      text_color_r    <= '1;
    end else if (cfg_write) begin
      // Take each value in its register's width; addresses past the map drop the word.
      unique case (reg_idx)
        tcgb_pkg::REG_FRAME_BASE:    frame_base_r    <= cfg_pwdata;
        tcgb_pkg::REG_LINE_STRIDE:   line_stride_r   <= cfg_pwdata[tcgb_pkg::CUR_W-1:0];
        tcgb_pkg::REG_SCREEN_WIDTH:  screen_width_r  <= cfg_pwdata[tcgb_pkg::CUR_W-1:0];
        tcgb_pkg::REG_SCREEN_HEIGHT: screen_height_r <= cfg_pwdata[tcgb_pkg::CUR_W-1:0];
        tcgb_pkg::REG_TEXT_COLOR:    text_color_r    <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tcgb_pkg::REG_FRAME_BASE:    cfg_prdata = frame_base_r;
      tcgb_pkg::REG_LINE_STRIDE:   cfg_prdata = tcgb_pkg::DATA_W'(line_stride_r);
      tcgb_pkg::REG_SCREEN_WIDTH:  cfg_prdata = tcgb_pkg::DATA_W'(screen_width_r);
      tcgb_pkg::REG_SCREEN_HEIGHT: cfg_prdata = tcgb_pkg::DATA_W'(screen_height_r);
      tcgb_pkg::REG_TEXT_COLOR:    cfg_prdata = text_color_r;
      default:                     cfg_prdata = '0;
    endcase
  end

  // Front end: track the cursor, decide clears and wraps, queue the work.
  tcgb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_char_code  (in_char_code),
    .in_font_row   (in_font_row),
    .in_font_bits  (in_font_bits),
    .screen_width  (screen_width_r),
    .screen_height (screen_height_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  // Short command queue decoupling the two halves.
  tcgb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_rdata)
  );

  // Back end: own the font store, generate clear and glyph-row words.
  tcgb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_data           (q_rdata),
    .q_pop            (q_pop),
    .frame_base       (frame_base_r),
    .line_stride      (line_stride_r),
    .text_color       (text_color_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_byte_address (out_byte_address),
    .out_row_mask     (out_row_mask),
    .out_pixel_color  (out_pixel_color),
    .out_last         (out_last)
  );

endmodule

// ===== rtl/tcgb_front.sv =====
`timescale 1ns / 1ps

module tcgb_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [7:0]                    in_char_code,
  input  logic [3:0]                    in_font_row,
  input  logic [7:0]                    in_font_bits,
  input  logic [tcgb_pkg::CUR_W-1:0]    screen_width,
  input  logic [tcgb_pkg::CUR_W-1:0]    screen_height,
  input  logic                          q_full,
  output logic                          q_push,
  output tcgb_pkg::cmd_t                q_data
);

  logic [tcgb_pkg::CUR_W-1:0] cur_x_r, cur_x_nxt;
  logic [tcgb_pkg::CUR_W-1:0] cur_y_r, cur_y_nxt;
  logic                       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    logic                       pre;
    logic [tcgb_pkg::CUR_W-1:0] hx, hy, x1, y1;
    logic                       push;
    pre  = cur_y_r > {1'b0, screen_height[tcgb_pkg::CUR_W-1:1]};
    hx   = pre ? tcgb_pkg::CUR_HOME_X : cur_x_r;
    hy   = pre ? tcgb_pkg::CUR_HOME_Y : cur_y_r;
    x1   = cur_x_r;
    y1   = cur_y_r;
    push = 1'b0;
    q_data           = '0;
    q_data.kind      = tcgb_pkg::CMD_CLEAR;
    q_data.pre_clear = pre;
    q_data.x         = hx;
    q_data.y         = hy;
    q_data.glyph     = tcgb_pkg::GLYPH_IDX_W'(in_char_code);
    q_data.row       = tcgb_pkg::ROW_W'(in_font_row);
    q_data.bits      = in_font_bits;
    unique case (tcgb_pkg::opcode_t'(in_opcode))
      tcgb_pkg::OP_PRINT: begin
        if (in_char_code != tcgb_pkg::CHAR_NUL) begin
          if (in_char_code == tcgb_pkg::CHAR_LF) begin
            x1   = tcgb_pkg::CUR_HOME_X;
            y1   = tcgb_pkg::sat_add(hy, tcgb_pkg::LINE_STEP);
            push = pre;
          end else if (in_char_code == tcgb_pkg::CHAR_TAB) begin
            x1   = tcgb_pkg::sat_add(hx, tcgb_pkg::TAB_STEP);
            y1   = hy;
            push = pre;
          end else begin
            x1          = tcgb_pkg::sat_add(hx, tcgb_pkg::CHAR_STEP);
            y1          = hy;
            push        = 1'b1;
            q_data.kind = tcgb_pkg::CMD_GLYPH;
          end
          // wrap the cursor onto the next text line
          if (x1 > screen_width) begin
            x1 = tcgb_pkg::CUR_HOME_X;
            y1 = tcgb_pkg::sat_add(y1, tcgb_pkg::LINE_STEP);
          end
        end
      end
      tcgb_pkg::OP_LOAD: begin
        q_data.kind = tcgb_pkg::CMD_LOAD;
        push        = int'(in_char_code) < tcgb_pkg::GLYPH_COUNT;
      end
      tcgb_pkg::OP_CLEAR: begin
        x1   = tcgb_pkg::CUR_HOME_X;
        y1   = tcgb_pkg::CUR_HOME_Y;
        push = 1'b1;
      end
      tcgb_pkg::OP_NONE: begin
        push = 1'b0;
      end
      default: begin
        push = 1'b0;
      end
    endcase
    q_push    = accept && push;
    cur_x_nxt = accept ? x1 : cur_x_r;
    cur_y_nxt = accept ? y1 : cur_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= tcgb_pkg::CUR_HOME_X;
      cur_y_r <= tcgb_pkg::CUR_HOME_Y;
    end else begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
    end
  end

endmodule

// ===== rtl/tcgb_queue.sv =====
`timescale 1ns / 1ps

module tcgb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tcgb_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output tcgb_pkg::cmd_t pop_data
);

  tcgb_pkg::cmd_t                 entries_r [tcgb_pkg::Q_DEPTH];
  logic [tcgb_pkg::Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [tcgb_pkg::Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [tcgb_pkg::Q_PTR_W:0]     count_r, count_nxt;
  logic                           do_push, do_pop;

  assign full      = count_r == (tcgb_pkg::Q_PTR_W + 1)'(tcgb_pkg::Q_DEPTH);
  assign pop_valid = count_r != '0;
  assign pop_data  = entries_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {{tcgb_pkg::Q_PTR_W{1'b0}}, do_push}
                         - {{tcgb_pkg::Q_PTR_W{1'b0}}, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/tcgb_back.sv =====
`timescale 1ns / 1ps

module tcgb_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  tcgb_pkg::cmd_t                 q_data,
  output logic                           q_pop,
  input  logic [31:0]                    frame_base,
  input  logic [tcgb_pkg::CUR_W-1:0]     line_stride,
  input  logic [31:0]                    text_color,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_kind,
  output logic [tcgb_pkg::ADDR_W-1:0]    out_byte_address,
  output logic [7:0]                     out_row_mask,
  output logic [31:0]                    out_pixel_color,
  output logic                           out_last
);

  tcgb_pkg::bstate_t                 state_r, state_nxt;
  tcgb_pkg::cmd_t                    cmd_r, cmd_nxt;
  logic [tcgb_pkg::ROW_W-1:0]        row_r, row_nxt;
  logic [tcgb_pkg::OFF_W-1:0]        off_r, off_nxt;
  logic [2*tcgb_pkg::CUR_W-1:0]      prod;

  logic [7:0]                        font_mem [tcgb_pkg::FONT_DEPTH];
  logic [7:0]                        rd_data_r;
  logic [tcgb_pkg::FONT_AW-1:0]      rd_addr;
  logic                              wr_en;

  logic                              out_valid_r, out_valid_nxt;
  logic                              out_kind_r, out_kind_nxt;
  logic [tcgb_pkg::ADDR_W-1:0]       out_addr_r, out_addr_nxt;
  logic [7:0]                        out_mask_r, out_mask_nxt;
  logic [31:0]                       out_color_r, out_color_nxt;
  logic                              out_last_r, out_last_nxt;
  logic                              can_emit;

  assign prod     = cmd_r.y * line_stride;
  assign can_emit = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    row_nxt       = row_r;
    off_nxt       = off_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_addr_nxt  = out_addr_r;
    out_mask_nxt  = out_mask_r;
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      tcgb_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_data;
          row_nxt = '0;
          unique case (q_data.kind)
            tcgb_pkg::CMD_LOAD:  wr_en = 1'b1;
            tcgb_pkg::CMD_CLEAR: state_nxt = tcgb_pkg::B_CLEAR;
            tcgb_pkg::CMD_GLYPH: begin
              state_nxt = q_data.pre_clear ? tcgb_pkg::B_CLEAR : tcgb_pkg::B_MUL;
            end
            default: state_nxt = tcgb_pkg::B_IDLE;
          endcase
        end
      end
      tcgb_pkg::B_CLEAR: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = tcgb_pkg::KIND_CLEAR;
          out_addr_nxt  = tcgb_pkg::ADDR_W'(frame_base);
          out_mask_nxt  = '0;
          out_color_nxt = '0;
          out_last_nxt  = cmd_r.kind == tcgb_pkg::CMD_CLEAR;
          state_nxt     = (cmd_r.kind == tcgb_pkg::CMD_GLYPH) ? tcgb_pkg::B_MUL
                                                              : tcgb_pkg::B_IDLE;
        end
      end
      tcgb_pkg::B_MUL: begin
        off_nxt   = tcgb_pkg::OFF_W'(cmd_r.x) + tcgb_pkg::OFF_W'(prod);
        state_nxt = tcgb_pkg::B_ROWS;
      end
      tcgb_pkg::B_ROWS: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = tcgb_pkg::KIND_ROW;
          out_addr_nxt  = tcgb_pkg::ADDR_W'(frame_base)
                        + tcgb_pkg::ADDR_W'({off_r, 2'b00});
          out_mask_nxt  = rd_data_r;
          out_color_nxt = text_color;
          out_last_nxt  = row_r == tcgb_pkg::ROW_LAST;
          row_nxt       = row_r + 1'b1;
          off_nxt       = off_r + tcgb_pkg::OFF_W'(line_stride);
          if (row_r == tcgb_pkg::ROW_LAST) begin
            state_nxt = tcgb_pkg::B_IDLE;
          end
        end
      end
      default: state_nxt = tcgb_pkg::B_IDLE;
    endcase
    // look ahead one row so the registered read lines up with row_r
    rd_addr = {cmd_nxt.glyph, row_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcgb_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    row_r       <= row_nxt;
    off_r       <= off_nxt;
    out_kind_r  <= out_kind_nxt;
    out_addr_r  <= out_addr_nxt;
    out_mask_r  <= out_mask_nxt;
    out_color_r <= out_color_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      font_mem[{q_data.glyph, q_data.row}] <= q_data.bits;
    end
    rd_data_r <= font_mem[rd_addr];
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_byte_address = out_addr_r;
  assign out_row_mask     = out_mask_r;
  assign out_pixel_color  = out_color_r;
  assign out_last         = out_last_r;

endmodule

// ===== tb/sv/glyph_write_checker.sv =====
`timescale 1ns / 1ps

module glyph_write_checker
  import tcgb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [1:0]          in_opcode,
  input  logic [7:0]          in_char_code,
  input  logic [3:0]          in_font_row,
  input  logic [7:0]          in_font_bits,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic                out_kind,
  input  logic [ADDR_W-1:0]   out_byte_address,
  input  logic [7:0]          out_row_mask,
  input  logic [31:0]         out_pixel_color,
  input  logic                out_last,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [PADDR_W-1:0]  cfg_paddr,
  input  logic [DATA_W-1:0]   cfg_pwdata,
  input  logic                cfg_pready,
  output int                  mismatches,
  output int                  writes_owed
);

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
    logic [31:0]       color;
    logic              last;
  } blit_word_t;

  blit_word_t       blits_due[$];
  int               fail_tally = 0;

  logic [31:0]      base_q;
  logic [CUR_W-1:0] stride_q;
  logic [CUR_W-1:0] width_q;
  logic [CUR_W-1:0] height_q;
  logic [31:0]      color_q;
  logic [CUR_W-1:0] pos_x;
  logic [CUR_W-1:0] pos_y;
  logic [7:0]       font_copy [FONT_DEPTH];

  // cursor moves clamp at the top of the 14-bit range
  function automatic logic [CUR_W-1:0] step_clamped(input logic [CUR_W-1:0] a,
                                                   input logic [CUR_W-1:0] b);
    int s;
    s = int'(a) + int'(b);
    return (s > int'(CUR_MAX)) ? CUR_MAX : CUR_W'(s);
  endfunction

  task automatic predict_blits(input opcode_t op, input logic [7:0] ch,
                               input logic [3:0] row, input logic [7:0] bits);
    blit_word_t burst[$];
    blit_word_t wipe;
    logic [63:0] pix_addr;
    int r;
    wipe = '{kind: KIND_CLEAR, addr: ADDR_W'(base_q), mask: '0, color: '0, last: 1'b0};
    case (op)
      OP_LOAD: font_copy[int'(ch) * GLYPH_ROWS + int'(row)] = bits;
      OP_CLEAR: begin
        burst.push_back(wipe);
        pos_x = CUR_HOME_X;
        pos_y = CUR_HOME_Y;
      end
      OP_PRINT: if (ch != CHAR_NUL) begin
        // scroll-free console: past half height, clear and home first
        if (pos_y > (height_q >> 1)) begin
          burst.push_back(wipe);
          pos_x = CUR_HOME_X;
          pos_y = CUR_HOME_Y;
        end
        if (ch == CHAR_LF) begin
          pos_x = CUR_HOME_X;
          pos_y = step_clamped(pos_y, LINE_STEP);
        end else if (ch == CHAR_TAB) begin
          pos_x = step_clamped(pos_x, TAB_STEP);
        end else begin
          for (r = 0; r < GLYPH_ROWS; r++) begin
            pix_addr = 64'(base_q) + 64'd4 * (64'(pos_x) + (64'(pos_y) + 64'(r)) * 64'(stride_q));
            burst.push_back('{kind: KIND_ROW, addr: pix_addr[ADDR_W-1:0],
                              mask: font_copy[(int'(ch) % GLYPH_COUNT) * GLYPH_ROWS + r],
                              color: color_q, last: 1'b0});
          end
          pos_x = step_clamped(pos_x, CHAR_STEP);
        end
        if (pos_x > width_q) begin
          pos_x = CUR_HOME_X;
          pos_y = step_clamped(pos_y, LINE_STEP);
        end
      end
      default: ;
    endcase
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) blits_due.push_back(burst[i]);
  endtask

  always @(posedge clk) begin : watch
    blit_word_t want;
    if (!rst_n) begin
      base_q   = '0;
      stride_q = CUR_W'(1024);
      width_q  = CUR_W'(1024);
      height_q = CUR_W'(768);
      color_q  = '1;
      pos_x    = CUR_HOME_X;
      pos_y    = CUR_HOME_Y;
      blits_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[PADDR_W-1:2])
          REG_FRAME_BASE:    base_q   = cfg_pwdata;
          REG_LINE_STRIDE:   stride_q = cfg_pwdata[CUR_W-1:0];
          REG_SCREEN_WIDTH:  width_q  = cfg_pwdata[CUR_W-1:0];
          REG_SCREEN_HEIGHT: height_q = cfg_pwdata[CUR_W-1:0];
          REG_TEXT_COLOR:    color_q  = cfg_pwdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        predict_blits(opcode_t'(in_opcode), in_char_code, in_font_row, in_font_bits);
      if (out_valid && !out_stall) begin
        if (blits_due.size() == 0) begin
          $error("unexpected result word: kind %0d byte_address %h", out_kind, out_byte_address);
          fail_tally++;
        end else begin
          want = blits_due.pop_front();
          if (out_kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_kind);
            fail_tally++;
          end
          if (out_byte_address !== want.addr) begin
            $error("byte_address: expected %h, got %h", want.addr, out_byte_address);
            fail_tally++;
          end
          if (out_row_mask !== want.mask) begin
            $error("row_mask: expected %h, got %h", want.mask, out_row_mask);
            fail_tally++;
          end
          if (out_pixel_color !== want.color) begin
            $error("pixel_color: expected %h, got %h", want.color, out_pixel_color);
            fail_tally++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            fail_tally++;
          end
        end
      end
    end
    writes_owed <= blits_due.size();
    mismatches  <= fail_tally;
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tcgb_pkg::*;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [1:0]          in_opcode    = '0;
  logic [7:0]          in_char_code = '0;
  logic [3:0]          in_font_row  = '0;
  logic [7:0]          in_font_bits = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic                out_kind;
  logic [ADDR_W-1:0]   out_byte_address;
  logic [7:0]          out_row_mask;
  logic [31:0]         out_pixel_color;
  logic                out_last;
  logic                cfg_psel     = 1'b0;
  logic                cfg_penable  = 1'b0;
  logic                cfg_pwrite   = 1'b0;
  logic [PADDR_W-1:0]  cfg_paddr    = '0;
  logic [DATA_W-1:0]   cfg_pwdata   = '0;
  logic [DATA_W-1:0]   cfg_prdata;
  logic                cfg_pready;

  int                  mismatches;
  int                  writes_owed;

  // word gaps on the command side are switched off for a whole chunk at a time
  bit                  calm;
  // which font rows each glyph has had written; a glyph is printable once all 16 are in
  logic [15:0]         rows_loaded [GLYPH_COUNT];
  logic [7:0]          printable[$];
  int                  stall_hold = 0;

  always #5 clk = ~clk;

  text_console_glyph_blitter DUT (.*);

  glyph_write_checker glyph_check (.*);

  // Result side back-pressure: mostly short stalls, now and then a long one, with
  // long free-running stretches mixed in.
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold--;
    end else if ($urandom_range(0, 99) < 35) begin
      out_stall  <= 1'b1;
      stall_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      out_stall  <= 1'b0;
      stall_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 4);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #12_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int pause_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Present one command word and hold it until the block takes it. Valid stays high
  // afterwards so that back-to-back words need no second assignment in one step.
  task automatic send_word(input opcode_t op, input logic [7:0] ch,
                           input logic [3:0] row, input logic [7:0] bits);
    int gap;
    logic [15:0] prior;
    gap = pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_char_code <= ch;
    in_font_row  <= row;
    in_font_bits <= bits;
    do @(posedge clk); while (in_stall);
    if (op == OP_LOAD) begin
      prior = rows_loaded[ch];
      rows_loaded[ch][row] = 1'b1;
      if (prior != '1 && rows_loaded[ch] == '1) printable.push_back(ch);
    end
  endtask

  // Fill all 16 rows of one glyph, starting at a random row; extreme patterns
  // turn up more often than pure chance would give them.
  task automatic load_glyph(input logic [7:0] ch);
    int off, k, pick;
    logic [7:0] bits;
    off = $urandom_range(0, 15);
    for (k = 0; k < GLYPH_ROWS; k++) begin
      pick = $urandom_range(0, 7);
      bits = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : (pick == 2) ? 8'h80 : 8'($urandom);
      send_word(OP_LOAD, ch, 4'((k + off) % GLYPH_ROWS), bits);
    end
  endtask

  // Drop valid, wait for every owed result, then let the block settle so that
  // any trailing font loads have left its queue before registers change.
  task automatic drain(input int settle);
    int k;
    in_valid <= 1'b0;
    k = 0;
    do begin
      @(posedge clk);
      k++;
    end while (writes_owed != 0 && k < 20000);
    repeat (settle) @(posedge clk);
  endtask

  // Program all five registers through setup and access cycles, then release the bus.
  task automatic program_registers(input logic [31:0] base, input int unsigned stride,
                                   input int unsigned width, input int unsigned height,
                                   input logic [31:0] color);
    logic [31:0] vals [5];
    int i;
    vals = '{base, stride, width, height, color};
    for (i = REG_FRAME_BASE; i <= REG_TEXT_COLOR; i++) begin
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b1;
      cfg_paddr   <= PADDR_W'(4 * i);
      cfg_pwdata  <= vals[i];
      @(posedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (!cfg_pready);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int p, counted, pick, run, k;
    foreach (rows_loaded[g]) rows_loaded[g] = '0;
    calm = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening at reset register values: control characters before any
    // glyph exists, the ignored opcode, an explicit clear, then a full glyph.
    send_word(OP_PRINT, CHAR_LF, 4'h0, 8'h00);
    send_word(OP_PRINT, CHAR_TAB, 4'hF, 8'hFF);
    send_word(OP_PRINT, CHAR_NUL, 4'h5, 8'hA5);
    send_word(OP_NONE, 8'hFF, 4'hF, 8'hFF);
    send_word(OP_CLEAR, 8'h00, 4'h0, 8'h00);
    load_glyph(8'hFF);
    send_word(OP_PRINT, 8'hFF, 4'h0, 8'h00);
    send_word(OP_PRINT, 8'hFF, 4'hF, 8'hFF);
    send_word(OP_PRINT, CHAR_TAB, 4'h0, 8'h00);
    send_word(OP_PRINT, 8'hFF, 4'h3, 8'h3C);

    // Random phases, each under its own register setting: both extremes first.
    for (p = 0; p < 5; p++) begin
      drain(30);
      case (p)
        0: program_registers(32'hFFFF_FFFF, 8192, 8192, 8192, 32'h0);
        1: program_registers(32'h0, 1, 8, 16, 32'hFFFF_FFFF);
        default: program_registers($urandom, $urandom_range(1, (p == 3) ? 64 : 8192),
                                   $urandom_range(8, (p == 3) ? 48 : 320),
                                   $urandom_range(16, (p == 3) ? 64 : 256), $urandom);
      endcase

      counted = 0;
      while (counted < 52) begin
        calm = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          load_glyph(8'($urandom_range(1, 255)));
          counted += GLYPH_ROWS;
        end else if (pick < 82) begin
          // a line of text: mostly known glyphs, with layout characters mixed in
          run = $urandom_range(3, 12);
          repeat (run) begin
            k = $urandom_range(0, 99);
            if (k < 70) begin
              send_word(OP_PRINT, printable[$urandom_range(0, printable.size() - 1)],
                        4'($urandom), 8'($urandom));
              counted++;
            end else if (k < 82) begin
              send_word(OP_PRINT, CHAR_LF, 4'($urandom), 8'($urandom));
              counted++;
            end else if (k < 92) begin
              send_word(OP_PRINT, CHAR_TAB, 4'($urandom), 8'($urandom));
              counted++;
            end else if (k < 96) begin
              send_word(OP_PRINT, CHAR_NUL, 4'($urandom), 8'($urandom));
            end else begin
              send_word(OP_CLEAR, 8'($urandom), 4'($urandom), 8'($urandom));
              counted++;
            end
          end
        end else begin
          // noise: ignored words and stray single-row loads
          k = $urandom_range(0, 2);
          if (k == 0) begin
            send_word(OP_NONE, 8'($urandom), 4'($urandom), 8'($urandom));
          end else if (k == 1) begin
            send_word(OP_LOAD, 8'($urandom), 4'($urandom), 8'($urandom));
            counted++;
          end else begin
            send_word(OP_PRINT, CHAR_NUL, 4'($urandom), 8'($urandom));
          end
        end
      end
    end

    drain(40);
    if (writes_owed != 0) $error("%0d result words never arrived", writes_owed);
    if (mismatches == 0 && writes_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
